@@ src/flp_pkg.sv @@
// Package with the shared types and constants of the length-prefixed frame parser.
`timescale 1ns / 1ps
`default_nettype none

package flp_pkg;

    localparam int LENGTH_BITS = 20;
    localparam int FRAME_LEN_W = 20;
    localparam int BYTE_W = 8;
    localparam int ACC_W = LENGTH_BITS + 4;

    localparam logic [BYTE_W-1:0] NUL_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;

    typedef enum logic [1:0] {
        PH_DIGITS  = 2'd0,
        PH_NAME    = 2'd1,
        PH_PAYLOAD = 2'd2,
        PH_DEAD    = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NAME    = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                  kind;
        logic [BYTE_W-1:0]      data_byte;
        logic [FRAME_LEN_W-1:0] frame_length;
        logic                   last;
    } flp_result_t;

endpackage

`default_nettype wire

@@ src/flp_out_buf.sv @@
// Output register with a skid stage for the parser's result beats.
`timescale 1ns / 1ps
`default_nettype none

module flp_out_buf (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire flp_pkg::flp_result_t  push_data,
    output logic                       full,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output flp_pkg::flp_result_t       out_data
);

    logic                 main_valid_reg;
    logic                 main_valid_next;
    flp_pkg::flp_result_t main_data_reg;
    flp_pkg::flp_result_t main_data_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    flp_pkg::flp_result_t skid_data_reg;
    flp_pkg::flp_result_t skid_data_next;
    logic                 pop;

    assign pop = main_valid_reg && !out_stall;
    assign full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data = main_data_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_data_next = main_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next = skid_data_reg;
        if (pop || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_valid_next = 1'b1;
                main_data_next = push_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("Result beat pushed while the skid stage is occupied.");

    a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("Skid stage holds a beat while the output register is empty.");

    a_stalled_fill_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (main_valid_reg && out_stall && push) |=> (skid_valid_reg && main_valid_reg))
        else $error("A beat pushed behind a stalled output was lost.");

endmodule

`default_nettype wire

@@ src/flp_parser.sv @@
// Input register and per-byte frame parsing state machine.
`timescale 1ns / 1ps
`default_nettype none

module flp_parser (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [flp_pkg::BYTE_W-1:0]      byte_in,
    input  wire logic                            full,
    output logic                                 push,
    output flp_pkg::flp_result_t                 push_data
);

    logic                              hold_valid_reg;
    logic                              hold_valid_next;
    logic [flp_pkg::BYTE_W-1:0]        hold_byte_reg;
    logic                              fire;
    logic                              accept;

    flp_pkg::phase_t                   phase_reg;
    flp_pkg::phase_t                   phase_next;
    logic [flp_pkg::LENGTH_BITS-1:0]   count_reg;
    logic [flp_pkg::LENGTH_BITS-1:0]   count_next;
    logic                              seen_digit_reg;
    logic                              seen_digit_next;

    logic                              is_digit;
    logic [flp_pkg::ACC_W-1:0]         count_ext;
    logic [flp_pkg::ACC_W-1:0]         acc;
    logic                              too_large;
    logic                              count_zero;
    logic [flp_pkg::LENGTH_BITS-1:0]   count_dec;

    assign in_stall = hold_valid_reg && full;
    assign accept = in_valid && !in_stall;
    assign fire = hold_valid_reg && !full;

    assign is_digit = hold_byte_reg inside {[flp_pkg::DIGIT_ZERO:flp_pkg::DIGIT_NINE]};
    assign count_ext = {4'b0000, count_reg};
    assign acc = (count_ext << 3) + (count_ext << 1)
        + flp_pkg::ACC_W'(hold_byte_reg - flp_pkg::DIGIT_ZERO);
    assign too_large = acc[flp_pkg::ACC_W-1:flp_pkg::LENGTH_BITS] != 4'b0000;
    assign count_zero = count_reg == '0;
    assign count_dec = count_zero ? count_reg : count_reg - 1'b1;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (fire)
        begin
            hold_valid_next = 1'b0;
        end
    end

    // Next phase and the length counter.
    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        seen_digit_next = seen_digit_reg;
        if (fire)
        begin
            case (phase_reg)
                flp_pkg::PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (too_large)
                        begin
                            phase_next = flp_pkg::PH_DEAD;
                        end
                        else
                        begin
                            count_next = acc[flp_pkg::LENGTH_BITS-1:0];
                            seen_digit_next = 1'b1;
                        end
                    end
                    else if (hold_byte_reg == flp_pkg::NUL_BYTE && seen_digit_reg)
                    begin
                        phase_next = flp_pkg::PH_NAME;
                    end
                    else
                    begin
                        phase_next = flp_pkg::PH_DEAD;
                    end
                end
                flp_pkg::PH_NAME:
                begin
                    if (hold_byte_reg == flp_pkg::NUL_BYTE)
                    begin
                        if (count_zero)
                        begin
                            phase_next = flp_pkg::PH_DIGITS;
                            seen_digit_next = 1'b0;
                        end
                        else
                        begin
                            phase_next = flp_pkg::PH_PAYLOAD;
                        end
                    end
                end
                flp_pkg::PH_PAYLOAD:
                begin
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        phase_next = flp_pkg::PH_DIGITS;
                        seen_digit_next = 1'b0;
                    end
                end
                default:
                begin
                    phase_next = flp_pkg::PH_DEAD;
                end
            endcase
        end
    end

    // Result beat for the byte in the input register.
    always_comb
    begin
        push = 1'b0;
        push_data.kind = flp_pkg::KIND_ERROR;
        push_data.data_byte = '0;
        push_data.frame_length = '0;
        push_data.last = 1'b0;
        case (phase_reg)
            flp_pkg::PH_DIGITS:
            begin
                if ((is_digit && too_large)
                    || (!is_digit
                        && !(hold_byte_reg == flp_pkg::NUL_BYTE && seen_digit_reg)))
                begin
                    push = fire;
                end
            end
            flp_pkg::PH_NAME:
            begin
                push = fire;
                if (hold_byte_reg != flp_pkg::NUL_BYTE)
                begin
                    push_data.kind = flp_pkg::KIND_NAME;
                    push_data.data_byte = hold_byte_reg;
                end
                else
                begin
                    push_data.kind = flp_pkg::KIND_HEADER;
                    push_data.frame_length = flp_pkg::FRAME_LEN_W'(count_reg);
                    push_data.last = count_zero;
                end
            end
            flp_pkg::PH_PAYLOAD:
            begin
                push = fire;
                push_data.kind = flp_pkg::KIND_PAYLOAD;
                push_data.data_byte = hold_byte_reg;
                push_data.last = count_dec == '0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            phase_reg <= flp_pkg::PH_DIGITS;
            count_reg <= '0;
            seen_digit_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            seen_digit_reg <= seen_digit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_byte_reg <= byte_in;
        end
    end

    a_error_goes_dead: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.kind == flp_pkg::KIND_ERROR) |=> phase_reg == flp_pkg::PH_DEAD)
        else $error("Error beat sent without entering the dead phase.");

    a_dead_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == flp_pkg::PH_DEAD |-> !push)
        else $error("Result beat sent in the dead phase.");

    a_dead_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == flp_pkg::PH_DEAD |=> phase_reg == flp_pkg::PH_DEAD)
        else $error("Parser left the dead phase without a reset.");

    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == flp_pkg::PH_PAYLOAD |-> !count_zero)
        else $error("Payload phase with no payload bytes left.");

endmodule

`default_nettype wire

@@ src/length_prefixed_frame_parser.sv @@
// Top level of the length-prefixed frame parser.
// The parser takes one byte beat per cycle while in_stall is low and gives at
// most one result beat per byte: name bytes, a header beat with the parsed
// length at the NUL that ends the name, then the payload bytes with last on
// the final one. A bad length gives one error beat, after which every byte is
// dropped until reset. A byte is registered on input, then parsed by the
// state machine, and its result beat is registered in the output register
// before it is presented on the outputs. A skid stage behind the output
// register takes the beat produced while the output is stalled, and the
// input stalls only while that skid stage is occupied, so with no output
// stall one byte is accepted every cycle.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_parser (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [flp_pkg::BYTE_W-1:0]        byte_in,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             kind,
    output logic [flp_pkg::BYTE_W-1:0]             data_byte,
    output logic [flp_pkg::FRAME_LEN_W-1:0]        frame_length,
    output logic                                   last
);

    logic                 push;
    logic                 full;
    flp_pkg::flp_result_t push_data;
    flp_pkg::flp_result_t out_data;

    flp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .byte_in   (byte_in),
        .full      (full),
        .push      (push),
        .push_data (push_data)
    );

    flp_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign kind = out_data.kind;
    assign data_byte = out_data.data_byte;
    assign frame_length = out_data.frame_length;
    assign last = out_data.last;

endmodule

`default_nettype wire

@@ dv/length_prefixed_frame_parser_tb.sv @@
// Self-checking testbench for the length-prefixed frame parser.
`timescale 1ns / 1ps

module length_prefixed_frame_parser_tb;

    localparam int ITEMS = 1800;
    localparam int QUIET_FROM = ITEMS - 200;
    localparam int HOLD_AT = 500;
    localparam int HOLD_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 16;
    localparam longint unsigned LEN_LIMIT = (longint'(1) << flp_pkg::LENGTH_BITS) - 1;

    typedef struct packed {
        logic [flp_pkg::BYTE_W-1:0] value;
        logic                       typed;
        logic                       yields;
        flp_pkg::flp_result_t       res;
    } stim_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic [flp_pkg::BYTE_W-1:0]      byte_in = '0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic [1:0]                      kind;
    logic [flp_pkg::BYTE_W-1:0]      data_byte;
    logic [flp_pkg::FRAME_LEN_W-1:0] frame_length;
    logic                            last;

    flp_pkg::phase_t parse_phase = flp_pkg::PH_DIGITS;
    longint unsigned parse_count = 0;
    bit              parse_seen_digit = 1'b0;

    flp_pkg::flp_result_t expected_beats[$];
    int          errors = 0;
    int          bytes_sent = 0;
    int          beats_seen = 0;
    int          frames_seen = 0;
    int          empty_frames = 0;
    int          quiet_cycles = 0;
    int          in_gap_pct = 0;
    int          out_gap_pct = 0;
    bit          hold_phase = 1'b0;
    string       tail_desc;

    length_prefixed_frame_parser DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .byte_in      (byte_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .data_byte    (data_byte),
        .frame_length (frame_length),
        .last         (last)
    );

    always #6 clk = ~clk;

    function automatic void restart_frame();
        parse_phase = flp_pkg::PH_DIGITS;
        parse_count = 0;
        parse_seen_digit = 1'b0;
    endfunction

    function automatic bit parse_byte(input logic [flp_pkg::BYTE_W-1:0] b,
                                      output flp_pkg::flp_result_t r);
        longint unsigned nxt;
        r.kind = flp_pkg::KIND_ERROR;
        r.data_byte = '0;
        r.frame_length = '0;
        r.last = 1'b0;
        case (parse_phase)
            flp_pkg::PH_DIGITS:
            begin
                if (b >= flp_pkg::DIGIT_ZERO && b <= flp_pkg::DIGIT_NINE)
                begin
                    nxt = parse_count * 10 + longint'(b - flp_pkg::DIGIT_ZERO);
                    if (nxt > LEN_LIMIT)
                    begin
                        parse_phase = flp_pkg::PH_DEAD;
                        return 1'b1;
                    end
                    parse_count = nxt;
                    parse_seen_digit = 1'b1;
                    return 1'b0;
                end
                if (b == flp_pkg::NUL_BYTE && parse_seen_digit)
                begin
                    parse_phase = flp_pkg::PH_NAME;
                    return 1'b0;
                end
                parse_phase = flp_pkg::PH_DEAD;
                return 1'b1;
            end
            flp_pkg::PH_NAME:
            begin
                if (b != flp_pkg::NUL_BYTE)
                begin
                    r.kind = flp_pkg::KIND_NAME;
                    r.data_byte = b;
                    return 1'b1;
                end
                r.kind = flp_pkg::KIND_HEADER;
                if (parse_count == 0)
                begin
                    r.last = 1'b1;
                    restart_frame();
                end
                else
                begin
                    r.frame_length = parse_count[flp_pkg::FRAME_LEN_W-1:0];
                    parse_phase = flp_pkg::PH_PAYLOAD;
                end
                return 1'b1;
            end
            flp_pkg::PH_PAYLOAD:
            begin
                if (parse_count > 0)
                    parse_count--;
                r.kind = flp_pkg::KIND_PAYLOAD;
                r.data_byte = b;
                if (parse_count == 0)
                begin
                    r.last = 1'b1;
                    restart_frame();
                end
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic stim_row_t pred_row(input logic [flp_pkg::BYTE_W-1:0] v);
        stim_row_t row;
        row = '0;
        row.value = v;
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [flp_pkg::BYTE_W-1:0] v,
                                            input flp_pkg::kind_t k,
                                            input logic [flp_pkg::BYTE_W-1:0] d,
                                            input logic [flp_pkg::FRAME_LEN_W-1:0] len,
                                            input logic lst);
        stim_row_t row;
        row.value = v;
        row.typed = 1'b1;
        row.yields = 1'b1;
        row.res.kind = k;
        row.res.data_byte = d;
        row.res.frame_length = len;
        row.res.last = lst;
        return row;
    endfunction

    task automatic send_beat(input stim_row_t row);
        flp_pkg::flp_result_t predicted;
        bit                   yields;
        int                   gap;
        if (!hold_phase && $urandom_range(0, 99) < in_gap_pct)
        begin
            gap = $urandom_range(1, 18);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        byte_in <= row.value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        yields = parse_byte(row.value, predicted);
        if (row.typed)
        begin
            yields = row.yields;
            predicted = row.res;
        end
        if (yields)
            expected_beats = {expected_beats, predicted};
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(pred_row(s[i]));
    endtask

    task automatic send_frame();
        int len;
        int name_len;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            len = 0;
        else if (pick < 70)
            len = $urandom_range(1, 8);
        else if (pick < 95)
            len = $urandom_range(9, 40);
        else
            len = $urandom_range(41, 200);
        name_len = $urandom_range(0, 6);
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0)
            send_beat(pred_row(flp_pkg::DIGIT_ZERO));
        send_text($sformatf("%0d", len));
        send_beat(pred_row(flp_pkg::NUL_BYTE));
        repeat (name_len)
            send_beat(pred_row(8'($urandom_range(1, 255))));
        send_beat(pred_row(flp_pkg::NUL_BYTE));
        repeat (len)
            send_beat(pred_row(8'($urandom_range(0, 255))));
    endtask

    task automatic check_field(input string field, input longint unsigned exp_v,
                               input longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        flp_pkg::flp_result_t exp_beat;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_seen++;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, kind %0d data %0d length %0d last %0d",
                         $time, kind, data_byte, frame_length, last);
                errors++;
            end
            else
            begin
                exp_beat = expected_beats.pop_front();
                check_field("kind", exp_beat.kind, kind);
                check_field("data_byte", exp_beat.data_byte, data_byte);
                check_field("frame_length", exp_beat.frame_length, frame_length);
                check_field("last", exp_beat.last, last);
                if (exp_beat.last)
                    frames_seen++;
                if (exp_beat.kind == flp_pkg::KIND_HEADER && exp_beat.last)
                    empty_frames++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_beats.size());
            $display("length_prefixed_frame_parser test failed");
            $finish;
        end
    end

    initial
    begin : receiver
        int burst;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_phase)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_phase = 1'b0;
            end
            else if ($urandom_range(0, 99) < out_gap_pct)
            begin
                burst = $urandom_range(1, 18);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t stim_rows [25];
        int        frames_done;
        int        variant;
        bit        hold_done;
        stim_rows = '{
            pred_row("0"), pred_row(flp_pkg::NUL_BYTE),
            typed_row(flp_pkg::NUL_BYTE, flp_pkg::KIND_HEADER, 8'h00, 20'd0, 1'b1),
            pred_row("3"), pred_row(flp_pkg::NUL_BYTE),
            typed_row(8'h01, flp_pkg::KIND_NAME, 8'h01, 20'd0, 1'b0),
            typed_row(8'hFF, flp_pkg::KIND_NAME, 8'hFF, 20'd0, 1'b0),
            typed_row(flp_pkg::NUL_BYTE, flp_pkg::KIND_HEADER, 8'h00, 20'd3, 1'b0),
            typed_row(8'h00, flp_pkg::KIND_PAYLOAD, 8'h00, 20'd0, 1'b0),
            typed_row(8'hFF, flp_pkg::KIND_PAYLOAD, 8'hFF, 20'd0, 1'b0),
            typed_row(8'h80, flp_pkg::KIND_PAYLOAD, 8'h80, 20'd0, 1'b1),
            pred_row("0"), pred_row("0"), pred_row("2"), pred_row(flp_pkg::NUL_BYTE),
            pred_row(8'h7F), pred_row(flp_pkg::NUL_BYTE), pred_row(8'h5A), pred_row(8'hA5),
            pred_row("0"), pred_row("0"), pred_row("0"), pred_row(flp_pkg::NUL_BYTE),
            pred_row("9"),
            typed_row(flp_pkg::NUL_BYTE, flp_pkg::KIND_HEADER, 8'h00, 20'd0, 1'b1)
        };
        frames_done = 0;
        hold_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_rows[i])
            send_beat(stim_rows[i]);

        in_gap_pct = 20;
        out_gap_pct = 20;
        while (bytes_sent < ITEMS - 20)
        begin
            if (!hold_done && bytes_sent >= HOLD_AT)
            begin
                hold_phase = 1'b1;
                hold_done = 1'b1;
            end
            if (bytes_sent >= QUIET_FROM)
            begin
                in_gap_pct = 0;
                out_gap_pct = 0;
            end
            else if (frames_done % 20 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: in_gap_pct = 0;
                    1: in_gap_pct = 5;
                    2: in_gap_pct = 25;
                    default: in_gap_pct = 60;
                endcase
                case ($urandom_range(0, 3))
                    0: out_gap_pct = 0;
                    1: out_gap_pct = 5;
                    2: out_gap_pct = 25;
                    default: out_gap_pct = 60;
                endcase
            end
            send_frame();
            frames_done++;
        end
        wait (hold_phase == 1'b0);
        in_gap_pct = 0;
        out_gap_pct = 0;

        variant = $urandom_range(0, 3);
        case (variant)
            0:
            begin
                tail_desc = "a stray character in the length";
                send_text("12");
                send_beat(typed_row($urandom_range(0, 1) ? 8'($urandom_range(8'h3A, 8'hFF))
                                                        : 8'($urandom_range(8'h01, 8'h2F)),
                                    flp_pkg::KIND_ERROR, 8'h00, 20'd0, 1'b0));
            end
            1:
            begin
                tail_desc = "a length with no digits";
                send_beat(typed_row(flp_pkg::NUL_BYTE, flp_pkg::KIND_ERROR, 8'h00, 20'd0,
                                    1'b0));
            end
            2:
            begin
                tail_desc = "a length one above the limit";
                send_text("104857");
                send_beat(typed_row("6", flp_pkg::KIND_ERROR, 8'h00, 20'd0, 1'b0));
            end
            default:
            begin
                tail_desc = "the largest length, cut short in its payload";
                send_text("1048575");
                send_beat(pred_row(flp_pkg::NUL_BYTE));
                send_beat(pred_row(8'($urandom_range(1, 255))));
                send_beat(typed_row(flp_pkg::NUL_BYTE, flp_pkg::KIND_HEADER, 8'h00,
                                    20'hFFFFF, 1'b0));
            end
        endcase
        send_beat(pred_row(flp_pkg::NUL_BYTE));
        send_beat(pred_row("5"));
        send_beat(pred_row(flp_pkg::NUL_BYTE));
        repeat (6)
            send_beat(pred_row(8'($urandom_range(0, 255))));
        in_valid <= 1'b0;

        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes and checked %0d result beats over %0d completed frames",
                 bytes_sent, beats_seen, frames_seen);
        $display("(%0d empty); the stream ended on %s, with one long output hold.",
                 empty_frames, tail_desc);
        if (errors == 0)
            $display("length_prefixed_frame_parser test passed");
        else
            $display("length_prefixed_frame_parser test failed");
        $finish;
    end

endmodule

@@ files.f @@
src/flp_pkg.sv
src/flp_out_buf.sv
src/flp_parser.sv
src/length_prefixed_frame_parser.sv
dv/length_prefixed_frame_parser_tb.sv
